// File: rtl/omt_pkg.sv
`default_nettype none
package omt_pkg;

  localparam int KEY_W     = 64;
  localparam int RANK_W    = 42;
  localparam int STATUS_W  = 2;
  localparam int OPCODE_W  = 4;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;

  localparam int DEF_ENTRIES    = 1024;
  localparam int DEF_COUNT_BITS = 32;

  // Keys are kept with the sign bit flipped so that unsigned order is signed order.
  localparam logic [KEY_W-1:0]  SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0]  NONE_VALUE = {KEY_W{1'b1}};
  localparam logic [RANK_W-1:0] TOTAL_MAX = {RANK_W{1'b1}};

  localparam logic [OPCODE_W-1:0] OP_INSERT   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_LESS     = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_AT_MOST  = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_AT_LEAST = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_GREATER  = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_KTH_SMALL = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_KTH_LARGE = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_FINAL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/omt_mem.sv
`default_nettype none
module omt_mem #(
  parameter int DEPTH = omt_pkg::DEF_ENTRIES,
  parameter int WIDTH = omt_pkg::KEY_W + omt_pkg::DEF_COUNT_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ordered_multiset_table.sv
`default_nettype none
// Ordered multiset of signed 64-bit keys, kept as a sorted table of distinct keys with a
// multiplicity each, in one single-port-read, single-port-write memory of ENTRIES rows.
// Every request is one in_ transfer and gives exactly one out_ transfer. A request first
// scans all rows in use, one row a cycle, which yields the insertion point, the hit, the
// four neighbors and the k-th element in one pass. An insert of a new key moves every row
// above the insertion point up by one, and deleting the last copy of a key moves the rows
// above it down, again one row a cycle through the memory. The next request is taken once
// the previous result sits in the output register, and that register may still wait on
// out_tready while the next request is in work. The table needs no clearing after reset:
// only rows below the distinct count are ever read.
module ordered_multiset_table #(
  parameter int ENTRIES    = omt_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = omt_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // opcode [3:0], key [67:4], rank [109:68], zero fill above
  input  wire logic [omt_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status [1:0], value [65:2], element_total [107:66], zero fill above
  output logic      [omt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int USED_W = $clog2(ENTRIES + 1);
  localparam int KEY_W  = omt_pkg::KEY_W;
  localparam int RANK_W = omt_pkg::RANK_W;
  localparam int MEM_W  = KEY_W + COUNT_BITS;
  localparam int ACC_W  = ((COUNT_BITS > RANK_W) ? COUNT_BITS : RANK_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  omt_pkg::state_t state_r, state_nxt;

  // Request registers.
  logic [omt_pkg::OPCODE_W-1:0] op_r;
  logic [KEY_W-1:0]             ukey_r;
  logic [RANK_W-1:0]            tgt_r;
  logic                         rk_ok_r;

  // Table bookkeeping.
  logic [USED_W-1:0] used_r;
  logic [RANK_W-1:0] total_r;

  // Scan results.
  logic [USED_W-1:0]     scan_idx_r;
  logic                  scan_vld_r;
  logic [USED_W-1:0]     pos_r;
  logic                  hit_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;
  logic [KEY_W-1:0]      lt_key_r, le_key_r, ge_key_r, gt_key_r, rk_key_r;
  logic                  lt_f_r, le_f_r, ge_f_r, gt_f_r, rk_f_r;
  logic [ACC_W-1:0]      acc_r;
  logic [ACC_W-1:0]      acc_sum;

  // Row move and the last single write.
  logic             sh_more_r, sh_up_r, sh_vld_r;
  logic [IDX_W-1:0] src_r, lim_r, sh_dst_r;
  logic             fin_en_r;
  logic [IDX_W-1:0] fin_addr_r;
  logic [MEM_W-1:0] fin_data_r;

  // Result.
  logic [omt_pkg::STATUS_W-1:0] res_status_r;
  logic [KEY_W-1:0]             res_value_r;
  logic                         out_valid_r;
  logic [omt_pkg::OUT_DATA_W-1:0] out_data_r;

  // Memory ports.
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [MEM_W-1:0] mem_wd, mem_rd;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;

  omt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign rd_key  = mem_rd[MEM_W-1:COUNT_BITS];
  assign rd_cnt  = mem_rd[COUNT_BITS-1:0];
  assign acc_sum = acc_r + ACC_W'(rd_cnt);

  assign in_tready  = (state_r == omt_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Memory port selection: the scan and the row move read, the move and the final write write.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = src_r;
    mem_we = 1'b0;
    mem_wa = fin_addr_r;
    mem_wd = fin_data_r;
    if (state_r == omt_pkg::S_SCAN) begin
      mem_re = (scan_idx_r < used_r);
      mem_ra = scan_idx_r[IDX_W-1:0];
    end else if (state_r == omt_pkg::S_SHIFT) begin
      mem_re = sh_more_r;
      mem_we = sh_vld_r;
      mem_wa = sh_dst_r;
      mem_wd = mem_rd;
    end else if (state_r == omt_pkg::S_FINAL) begin
      mem_we = fin_en_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      omt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = omt_pkg::S_SCAN;
        end
      end
      omt_pkg::S_SCAN: begin
        if (!(scan_idx_r < used_r) && !scan_vld_r) begin
          state_nxt = omt_pkg::S_DECIDE;
        end
      end
      omt_pkg::S_DECIDE: state_nxt = omt_pkg::S_SHIFT;
      omt_pkg::S_SHIFT: begin
        if (!sh_more_r && !sh_vld_r) begin
          state_nxt = omt_pkg::S_FINAL;
        end
      end
      omt_pkg::S_FINAL: state_nxt = omt_pkg::S_DONE;
      omt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = omt_pkg::S_IDLE;
        end
      end
      default: state_nxt = omt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= omt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bookkeeping and handshake control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r  <= 1'b0;
      sh_more_r   <= 1'b0;
      sh_vld_r    <= 1'b0;
      fin_en_r    <= 1'b0;
    end else begin
      if (state_r == omt_pkg::S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      scan_vld_r <= (state_r == omt_pkg::S_SCAN) && (scan_idx_r < used_r);

      if (state_r == omt_pkg::S_SHIFT) begin
        sh_vld_r <= sh_more_r;
        if (sh_more_r && src_r == lim_r) begin
          sh_more_r <= 1'b0;
        end
      end

      if (state_r == omt_pkg::S_DECIDE) begin
        sh_more_r <= 1'b0;
        fin_en_r  <= 1'b0;
        case (op_r)
          omt_pkg::OP_INSERT: begin
            if (total_r == omt_pkg::TOTAL_MAX) begin
            end else if (hit_r) begin
              if (hit_cnt_r != CNT_MAX) begin
                fin_en_r <= 1'b1;
                total_r  <= total_r + 1'b1;
              end
            end else if (used_r != USED_W'(ENTRIES)) begin
              fin_en_r  <= 1'b1;
              sh_more_r <= (pos_r < used_r);
              used_r    <= used_r + 1'b1;
              total_r   <= total_r + 1'b1;
            end
          end
          omt_pkg::OP_DELETE: begin
            if (hit_r) begin
              total_r <= total_r - 1'b1;
              if (hit_cnt_r > COUNT_BITS'(1)) begin
                fin_en_r <= 1'b1;
              end else begin
                sh_more_r <= ((pos_r + 1'b1) < used_r);
                used_r    <= used_r - 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      omt_pkg::S_IDLE: begin
        op_r       <= in_tdata[3:0];
        ukey_r     <= in_tdata[67:4] ^ omt_pkg::SIGN_FLIP;
        scan_idx_r <= '0;
        pos_r      <= '0;
        hit_r      <= 1'b0;
        hit_cnt_r  <= '0;
        lt_f_r     <= 1'b0;
        le_f_r     <= 1'b0;
        ge_f_r     <= 1'b0;
        gt_f_r     <= 1'b0;
        rk_f_r     <= 1'b0;
        acc_r      <= '0;
        rk_ok_r    <= (in_tdata[109:68] != '0) && (in_tdata[109:68] <= total_r);
        if (in_tdata[3:0] == omt_pkg::OP_KTH_LARGE) begin
          tgt_r <= total_r - in_tdata[109:68] + 1'b1;
        end else begin
          tgt_r <= in_tdata[109:68];
        end
      end
      omt_pkg::S_SCAN: begin
        if (scan_idx_r < used_r) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (scan_vld_r) begin
          acc_r <= acc_sum;
          if (!rk_f_r && ACC_W'(tgt_r) <= acc_sum) begin
            rk_f_r   <= 1'b1;
            rk_key_r <= rd_key;
          end
          if (rd_key < ukey_r) begin
            pos_r    <= pos_r + 1'b1;
            lt_f_r   <= 1'b1;
            lt_key_r <= rd_key;
            le_f_r   <= 1'b1;
            le_key_r <= rd_key;
          end else begin
            if (!ge_f_r) begin
              ge_f_r   <= 1'b1;
              ge_key_r <= rd_key;
            end
            if (rd_key == ukey_r) begin
              hit_r     <= 1'b1;
              hit_cnt_r <= rd_cnt;
              le_f_r    <= 1'b1;
              le_key_r  <= rd_key;
            end else if (!gt_f_r) begin
              gt_f_r   <= 1'b1;
              gt_key_r <= rd_key;
            end
          end
        end
      end
      omt_pkg::S_DECIDE: begin
        res_status_r <= omt_pkg::ST_NOT_FOUND;
        res_value_r  <= omt_pkg::NONE_VALUE;
        fin_addr_r   <= pos_r[IDX_W-1:0];
        fin_data_r   <= {ukey_r, COUNT_BITS'(1)};
        sh_up_r      <= (op_r == omt_pkg::OP_INSERT);
        if (op_r == omt_pkg::OP_INSERT) begin
          src_r <= IDX_W'(used_r - 1'b1);
          lim_r <= pos_r[IDX_W-1:0];
        end else begin
          src_r <= IDX_W'(pos_r + 1'b1);
          lim_r <= IDX_W'(used_r - 1'b1);
        end
        case (op_r)
          omt_pkg::OP_INSERT: begin
            if (total_r == omt_pkg::TOTAL_MAX) begin
              res_status_r <= omt_pkg::ST_FULL;
            end else if (hit_r) begin
              if (hit_cnt_r == CNT_MAX) begin
                res_status_r <= omt_pkg::ST_FULL;
              end else begin
                res_status_r <= omt_pkg::ST_OK;
                res_value_r  <= '0;
                fin_data_r   <= {ukey_r, hit_cnt_r + 1'b1};
              end
            end else if (used_r == USED_W'(ENTRIES)) begin
              res_status_r <= omt_pkg::ST_FULL;
            end else begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= '0;
            end
          end
          omt_pkg::OP_DELETE: begin
            if (hit_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= '0;
              fin_data_r   <= {ukey_r, hit_cnt_r - 1'b1};
            end
          end
          omt_pkg::OP_CONTAINS: begin
            res_status_r <= omt_pkg::ST_OK;
            res_value_r  <= KEY_W'(hit_r);
          end
          omt_pkg::OP_LESS: begin
            if (lt_f_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= lt_key_r ^ omt_pkg::SIGN_FLIP;
            end
          end
          omt_pkg::OP_AT_MOST: begin
            if (le_f_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= le_key_r ^ omt_pkg::SIGN_FLIP;
            end
          end
          omt_pkg::OP_AT_LEAST: begin
            if (ge_f_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= ge_key_r ^ omt_pkg::SIGN_FLIP;
            end
          end
          omt_pkg::OP_GREATER: begin
            if (gt_f_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= gt_key_r ^ omt_pkg::SIGN_FLIP;
            end
          end
          omt_pkg::OP_KTH_SMALL, omt_pkg::OP_KTH_LARGE: begin
            if (rk_ok_r && rk_f_r) begin
              res_status_r <= omt_pkg::ST_OK;
              res_value_r  <= rk_key_r ^ omt_pkg::SIGN_FLIP;
            end
          end
          default: begin
          end
        endcase
      end
      omt_pkg::S_SHIFT: begin
        // Each row read lands one place up or down on the next cycle.
        if (sh_more_r) begin
          sh_dst_r <= sh_up_r ? IDX_W'(src_r + 1'b1) : IDX_W'(src_r - 1'b1);
          if (src_r != lim_r) begin
            src_r <= sh_up_r ? IDX_W'(src_r - 1'b1) : IDX_W'(src_r + 1'b1);
          end
        end
      end
      omt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {{(omt_pkg::OUT_DATA_W - 108){1'b0}}, total_r, res_value_r,
                         res_status_r};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(ENTRIES))
    else $error("distinct count beyond table size");

  a_total_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    RANK_W'(used_r) <= total_r)
    else $error("fewer elements than distinct keys");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == omt_pkg::S_SCAN))
    else $error("accepted request did not start a scan");

  a_not_found_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[1:0] != omt_pkg::ST_OK) |->
      (out_data_r[65:2] == omt_pkg::NONE_VALUE))
    else $error("failed result carries a value");
`endif

endmodule
`default_nettype wire
